/* hdl/deq_pkg.sv */
package deq_pkg;

   // Operation codes carried on req_func
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // Side codes carried on req_at_end
   localparam logic SIDE_FRONT = 1'b0;
   localparam logic SIDE_END   = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Storage strobes from the controller to the slot memory
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

/* hdl/deq_mem.sv */
// Slot storage: one write port, one read port, registered read data.
module deq_mem #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32,
   parameter int IDX_W      = 8
) (
   input  logic                    clock,
   input  deq_pkg::mem_cmd_type    cmd,
   input  logic [IDX_W-1:0]        wr_addr,
   input  logic [DATA_WIDTH-1:0]   wr_data,
   input  logic [IDX_W-1:0]        rd_addr,
   output logic [DATA_WIDTH-1:0]   rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/deq_ctrl.sv */
// Deque controller: front/end pointers, count, cached front and end words.
// Inserts finish in the accept cycle; a remove that leaves one or more words
// reads the new front or end word from the slot memory in the S_READ state.
module deq_ctrl #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32,
   parameter int IDX_W      = 8,
   parameter int CNT_W      = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   // request side
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_func,
   input  logic                    req_at_end,
   input  logic [DATA_WIDTH-1:0]   req_value,
   // result toward the output register
   input  logic                    res_free,
   output logic                    res_valid,
   output logic [1:0]              res_status,
   output logic [DATA_WIDTH-1:0]   res_removed,
   output logic [DATA_WIDTH-1:0]   res_front,
   output logic [DATA_WIDTH-1:0]   res_end,
   output logic [CNT_W-1:0]        res_count,
   // slot memory
   output deq_pkg::mem_cmd_type    mem_cmd,
   output logic [IDX_W-1:0]        mem_wr_addr,
   output logic [DATA_WIDTH-1:0]   mem_wr_data,
   output logic [IDX_W-1:0]        mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]   mem_rd_data
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      front_idx_ff, front_idx_in;
   logic [IDX_W-1:0]      end_idx_ff, end_idx_in;
   logic [CNT_W-1:0]      held_ff, held_in;
   logic [DATA_WIDTH-1:0] front_val_ff, front_val_in;
   logic [DATA_WIDTH-1:0] end_val_ff, end_val_in;
   logic [DATA_WIDTH-1:0] taken_ff, taken_in;
   logic                  side_ff, side_in;

   logic                  accept;
   logic                  is_remove;
   logic                  is_end;
   logic                  empty;
   logic                  full;
   logic [IDX_W-1:0]      front_inc, front_dec, end_inc, end_dec;

   // circular index steps, valid for any depth
   assign front_inc = (front_idx_ff == IDX_LAST) ? '0 : front_idx_ff + 1'b1;
   assign front_dec = (front_idx_ff == '0) ? IDX_LAST : front_idx_ff - 1'b1;
   assign end_inc   = (end_idx_ff == IDX_LAST) ? '0 : end_idx_ff + 1'b1;
   assign end_dec   = (end_idx_ff == '0) ? IDX_LAST : end_idx_ff - 1'b1;

   assign req_ready = (state_ff == S_IDLE) && res_free;
   assign accept    = req_valid && req_ready;
   assign is_remove = (req_func == deq_pkg::FUNC_REMOVE);
   assign is_end    = (req_at_end == deq_pkg::SIDE_END);
   assign empty     = (held_ff == '0);
   assign full      = (held_ff == CNT_FULL);

   // next state, memory strobes and result
   always_comb begin
      state_in     = state_ff;
      front_idx_in = front_idx_ff;
      end_idx_in   = end_idx_ff;
      held_in      = held_ff;
      front_val_in = front_val_ff;
      end_val_in   = end_val_ff;
      taken_in     = taken_ff;
      side_in      = side_ff;

      mem_cmd     = '0;
      mem_wr_addr = front_dec;
      mem_wr_data = req_value;
      mem_rd_addr = front_inc;

      res_valid   = 1'b0;
      res_status  = deq_pkg::ST_OK;
      res_removed = '0;
      res_front   = '0;
      res_end     = '0;
      res_count   = held_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (is_remove && empty) begin
                  // refused: nothing held
                  res_valid  = 1'b1;
                  res_status = deq_pkg::ST_EMPTY;
               end else if (!is_remove && full) begin
                  // refused: no free slot
                  res_valid  = 1'b1;
                  res_status = deq_pkg::ST_FULL;
                  res_front  = front_val_ff;
                  res_end    = end_val_ff;
               end else if (!is_remove) begin
                  mem_cmd.wr_en = 1'b1;
                  held_in       = held_ff + 1'b1;
                  if (is_end) begin
                     end_idx_in  = end_inc;
                     mem_wr_addr = end_inc;
                     end_val_in  = req_value;
                     if (empty) begin
                        front_val_in = req_value;
                     end
                  end else begin
                     front_idx_in = front_dec;
                     mem_wr_addr  = front_dec;
                     front_val_in = req_value;
                     if (empty) begin
                        end_val_in = req_value;
                     end
                  end
                  res_valid = 1'b1;
                  res_front = front_val_in;
                  res_end   = end_val_in;
                  res_count = held_in;
               end else begin
                  held_in  = held_ff - 1'b1;
                  taken_in = is_end ? end_val_ff : front_val_ff;
                  side_in  = req_at_end;
                  if (is_end) begin
                     end_idx_in  = end_dec;
                     mem_rd_addr = end_dec;
                  end else begin
                     front_idx_in = front_inc;
                     mem_rd_addr  = front_inc;
                  end
                  if (held_ff == CNT_W'(1)) begin
                     // last word leaves: result is ready now
                     res_valid   = 1'b1;
                     res_removed = taken_in;
                     res_count   = held_in;
                  end else begin
                     mem_cmd.rd_en = 1'b1;
                     state_in      = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            // new front or end word arrives from memory
            if (side_ff == deq_pkg::SIDE_END) begin
               end_val_in = mem_rd_data;
            end else begin
               front_val_in = mem_rd_data;
            end
            res_valid   = 1'b1;
            res_removed = taken_ff;
            res_front   = front_val_in;
            res_end     = end_val_in;
            res_count   = held_ff;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_idx_ff <= '0;
         end_idx_ff   <= IDX_LAST;
         held_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         front_idx_ff <= front_idx_in;
         end_idx_ff   <= end_idx_in;
         held_ff      <= held_in;
      end
      front_val_ff <= front_val_in;
      end_val_ff   <= end_val_in;
      taken_ff     <= taken_in;
      side_ff      <= side_in;
   end

   // count never passes capacity
   assert property (@(posedge clock) disable iff (reset) held_ff <= CNT_FULL)
      else $error("deque count above capacity");

   // memory is never read and written in one cycle
   assert property (@(posedge clock) disable iff (reset) !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("slot memory read and write collide");

   // a read cycle only follows an accepted remove
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> $past(accept && is_remove))
      else $error("read cycle without a remove");

   // when empty, end pointer sits just before front pointer
   assert property (@(posedge clock) disable iff (reset)
      empty |-> (end_idx_ff == front_dec))
      else $error("pointers disagree with empty count");

   // the read cycle always hands over a result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> res_valid && res_free)
      else $error("read cycle result lost");

endmodule

/* hdl/double_ended_queue.sv */
// Bounded double-ended queue of DEPTH words of DATA_WIDTH bits.
// Request channel (req_*): req_func selects insert or remove, req_at_end
// selects the front or end side, req_value is the word to insert.
// Result channel (rsp_*): one word per request with status (ok, remove from
// empty, insert into full), the removed word, the front and end words after
// the operation (zero when empty) and the count held.
// Inserts, refused operations and a remove of the last word are settled in the
// accept cycle, and rsp_valid rises in the cycle after. A remove that leaves
// one or more words first passes the S_READ state: the new front or end word
// is read from the single-port-read slot memory, whose read data is registered.
// So inserts are taken at one item per cycle while the output register is free;
// a remove that reads memory holds req_ready low until S_READ ends.
// Results sit in an output register; while it is full and rsp_ready is low,
// req_ready drops, and a new request is taken in the cycle the result leaves.
// Reset (synchronous, active high) empties the queue at once; slot contents
// are not cleared and are never read before being written.
module double_ended_queue #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic                              req_at_end,
   input  logic [DATA_WIDTH-1:0]             req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [DATA_WIDTH-1:0]             rsp_removed_value,
   output logic [DATA_WIDTH-1:0]             rsp_front_value,
   output logic [DATA_WIDTH-1:0]             rsp_end_value,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   deq_pkg::mem_cmd_type    mem_cmd;
   logic [IDX_W-1:0]        mem_wr_addr;
   logic [DATA_WIDTH-1:0]   mem_wr_data;
   logic [IDX_W-1:0]        mem_rd_addr;
   logic [DATA_WIDTH-1:0]   mem_rd_data;

   logic                    res_free;
   logic                    res_valid;
   logic [1:0]              res_status;
   logic [DATA_WIDTH-1:0]   res_removed;
   logic [DATA_WIDTH-1:0]   res_front;
   logic [DATA_WIDTH-1:0]   res_end;
   logic [CNT_W-1:0]        res_count;

   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [DATA_WIDTH-1:0]   rsp_removed_ff;
   logic [DATA_WIDTH-1:0]   rsp_front_ff;
   logic [DATA_WIDTH-1:0]   rsp_end_ff;
   logic [CNT_W-1:0]        rsp_count_ff;

   deq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_at_end  (req_at_end),
      .req_value   (req_value),
      .res_free    (res_free),
      .res_valid   (res_valid),
      .res_status  (res_status),
      .res_removed (res_removed),
      .res_front   (res_front),
      .res_end     (res_end),
      .res_count   (res_count),
      .mem_cmd     (mem_cmd),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   deq_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W)
   ) u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register is free when empty or being drained this cycle
   assign res_free = !rsp_valid_ff || rsp_ready;

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid) begin
         rsp_status_ff  <= res_status;
         rsp_removed_ff <= res_removed;
         rsp_front_ff   <= res_front;
         rsp_end_ff     <= res_end;
         rsp_count_ff   <= res_count;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_front_value   = rsp_front_ff;
   assign rsp_end_value     = rsp_end_ff;
   assign rsp_count         = rsp_count_ff;

endmodule

/* tb/double_ended_queue_tb.sv */
module double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEQ_DEPTH   = 256;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic        func;
      logic        at_end;
      logic [31:0] value;
   } deq_op_type;

   typedef struct {
      deq_pkg::status_type status;
      logic [31:0]         removed;
      logic [31:0]         front;
      logic [31:0]         tail;
      logic [8:0]          count;
   } deq_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = deq_pkg::FUNC_INSERT;
   logic        req_at_end = deq_pkg::SIDE_FRONT;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_removed_value;
   logic [31:0] rsp_front_value;
   logic [31:0] rsp_end_value;
   logic [8:0]  rsp_count;

   // words waiting to be offered, and outcomes waiting to come back
   deq_op_type     op_backlog[$];
   deq_result_type deque_outcomes[$];
   deq_op_type     on_wire;

   // shadow deque state
   logic [31:0] deque_slots [DEQ_DEPTH];
   logic [7:0]  head_pos = '0;
   logic [8:0]  fill_level = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_request = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int fail_count = 0;

   double_ended_queue uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_at_end        (req_at_end),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_front_value   (rsp_front_value),
      .rsp_end_value     (rsp_end_value),
      .rsp_count         (rsp_count)
   );

   always #6 clock = ~clock;

   // Apply one operation to the shadow deque and return what the block should report
   function automatic deq_result_type apply_deque_op(deq_op_type op);
      deq_result_type r;
      logic [7:0]     slot_pos;
      r.status  = deq_pkg::ST_OK;
      r.removed = '0;
      r.front   = '0;
      r.tail    = '0;
      if (op.func == deq_pkg::FUNC_REMOVE) begin
         if (fill_level == 0) begin
            r.status = deq_pkg::ST_EMPTY;
         end else if (op.at_end == deq_pkg::SIDE_END) begin
            slot_pos = head_pos + fill_level[7:0] - 8'd1;
            r.removed = deque_slots[slot_pos];
            fill_level = fill_level - 9'd1;
         end else begin
            r.removed = deque_slots[head_pos];
            head_pos = head_pos + 8'd1;
            fill_level = fill_level - 9'd1;
         end
      end else begin
         if (fill_level == DEQ_DEPTH) begin
            r.status = deq_pkg::ST_FULL;
         end else if (op.at_end == deq_pkg::SIDE_END) begin
            slot_pos = head_pos + fill_level[7:0];
            deque_slots[slot_pos] = op.value;
            fill_level = fill_level + 9'd1;
         end else begin
            head_pos = head_pos - 8'd1;
            deque_slots[head_pos] = op.value;
            fill_level = fill_level + 9'd1;
         end
      end
      // front and end words after the step; a full deque wraps end to head-1
      if (fill_level != 0) begin
         slot_pos = head_pos + fill_level[7:0] - 8'd1;
         r.front = deque_slots[head_pos];
         r.tail  = deque_slots[slot_pos];
      end
      r.count = fill_level;
      return r;
   endfunction

   // Request driver: record the accepted word, then offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            deque_outcomes.push_back(apply_deque_op(on_wire));
         if (!req_valid || req_ready) begin
            if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_wire = op_backlog.pop_front();
               req_valid  <= 1'b1;
               req_func   <= on_wire.func;
               req_at_end <= on_wire.at_end;
               req_value  <= on_wire.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      end
   endtask

   // Result monitor: compare each word against the oldest outcome
   always @(posedge clock) begin : rsp_check
      deq_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (deque_outcomes.size() == 0) begin
            fail_count++;
            $display("%0t: result word with nothing pending, status %0d count %0d",
                     $time, rsp_status, rsp_count);
         end else begin
            want = deque_outcomes.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("removed_value", want.removed, rsp_removed_value);
            check_field("front_value", want.front, rsp_front_value);
            check_field("end_value", want.tail, rsp_end_value);
            check_field("count", 32'(want.count), 32'(rsp_count));
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_op(logic func, logic at_end, logic [31:0] value);
      deq_op_type op;
      op.func   = func;
      op.at_end = at_end;
      op.value  = value;
      op_backlog.push_back(op);
   endtask

   // Random run: remove_pct sets the drift toward empty or full
   task automatic queue_run(int n, int remove_pct);
      for (int i = 0; i < n; i++)
         push_op(($urandom_range(99) < remove_pct) ? deq_pkg::FUNC_REMOVE
                                                   : deq_pkg::FUNC_INSERT,
                 $urandom_range(1) ? deq_pkg::SIDE_END : deq_pkg::SIDE_FRONT, $urandom);
   endtask

   // Block until every word is sent and every outcome has come back
   task automatic settle();
      while (op_backlog.size() != 0 || req_valid || deque_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: empty removes, single element, extremes, both sides
      set_idling(0, 0);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_FRONT, $urandom);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_END,   $urandom);
      push_op(deq_pkg::FUNC_INSERT, deq_pkg::SIDE_FRONT, 32'h0000_0000);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_END,   $urandom);
      push_op(deq_pkg::FUNC_INSERT, deq_pkg::SIDE_END,   32'hFFFF_FFFF);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_FRONT, $urandom);
      push_op(deq_pkg::FUNC_INSERT, deq_pkg::SIDE_END,   32'hFFFF_FFFF);
      push_op(deq_pkg::FUNC_INSERT, deq_pkg::SIDE_FRONT, 32'h0000_0000);
      push_op(deq_pkg::FUNC_INSERT, deq_pkg::SIDE_END,   32'hA5A5_A5A5);
      push_op(deq_pkg::FUNC_INSERT, deq_pkg::SIDE_FRONT, 32'h5A5A_5A5A);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_FRONT, 32'hFFFF_FFFF);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_END,   32'h0000_0000);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_FRONT, $urandom);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_END,   $urandom);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_END,   $urandom);
      push_op(deq_pkg::FUNC_INSERT, deq_pkg::SIDE_FRONT, 32'h8000_0000);
      push_op(deq_pkg::FUNC_INSERT, deq_pkg::SIDE_FRONT, 32'h7FFF_FFFF);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_END,   $urandom);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_END,   $urandom);
      push_op(deq_pkg::FUNC_INSERT, deq_pkg::SIDE_END,   32'h0000_0001);
      push_op(deq_pkg::FUNC_REMOVE, deq_pkg::SIDE_FRONT, $urandom);
      settle();

      // fill to full with the receiver held off at first so the input backs up
      set_idling(0, 0);
      @(posedge clock);
      hold_request <= 1'b1;
      queue_run(280, 3);
      settle();

      // drain to empty with a bursty sender
      set_idling(72, 0);
      queue_run(280, 97);
      settle();

      // fill again against a stalling receiver
      set_idling(0, 72);
      queue_run(280, 3);
      settle();

      // churn near full, then drain partway, both sides idling
      set_idling(24, 24);
      queue_run(150, 50);
      queue_run(120, 97);
      settle();

      // finish draining at full rate
      set_idling(0, 0);
      queue_run(150, 97);
      settle();

      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
